### rtl/core/mbet_pkg.sv
// ----------------------------------------------------------------------------
// mbet_pkg
// shared types and constants of the escape-time core
// ----------------------------------------------------------------------------
package mbet_pkg;

  localparam int unsigned ROW_W      = 12;
  localparam int unsigned NUM_W      = ROW_W + 2;
  localparam int unsigned GRID_W     = 13;
  localparam int unsigned GRID_MAXV  = 8191;
  localparam int unsigned MAXIT_W    = 16;
  localparam int unsigned ITER_W     = 17;
  localparam int unsigned DIG_W      = 32;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [GRID_W-1:0]  GRID_RESET  = 13'd2048;
  localparam logic [MAXIT_W-1:0] MAXIT_RESET = 16'd1000;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 1'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_X,
    ST_DIV_Y,
    ST_ITER,
    ST_MUL_XX,
    ST_MUL_YY,
    ST_CHECK,
    ST_MUL_XY,
    ST_DONE
  } state_e;

endpackage

### rtl/core/mandelbrot_escape_time_core.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_core
// escape-time count for one pixel of a square grid, Q4.FracBits fixed point
// ----------------------------------------------------------------------------
// One pixel is in flight at a time and in_stall_o stays high while it is
// worked on. A bit-serial divider first maps row and column to c, one
// coordinate after the other. The escape loop then runs on a single shared
// multiplier, with three products and the ITER and CHECK control states
// per iteration. The result sits in an output register, so the next pixel
// is taken while it waits.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_core #(
  parameter int unsigned MaxGrid  = 4096,
  parameter int unsigned FracBits = 28
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mbet_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mbet_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [mbet_pkg::ROW_W-1:0]        row_i,
  input  logic [mbet_pkg::ROW_W-1:0]        col_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [mbet_pkg::ITER_W-1:0]       iter_count_o,
  output logic                              escaped_o
);

  localparam int unsigned W      = FracBits + 4;
  localparam int unsigned QW     = FracBits + 5;
  localparam int unsigned SqW    = FracBits + 7;
  localparam int unsigned SW     = FracBits + 9;
  localparam int unsigned PmW    = FracBits + 6;
  localparam int unsigned PmRawW = 2 * W - (FracBits - 1);
  localparam int unsigned GW     = mbet_pkg::GRID_W;
  localparam int unsigned NW     = mbet_pkg::NUM_W;
  localparam int unsigned RW     = mbet_pkg::ROW_W;
  localparam int unsigned IW     = mbet_pkg::ITER_W;

  localparam logic [GW-1:0] GridCap =
    GW'((MaxGrid > mbet_pkg::GRID_MAXV) ? mbet_pkg::GRID_MAXV : MaxGrid);
  localparam logic [W-1:0]         MagLim = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0]  QMax   = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  QMin   = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [SW-1:0] SatHi  = (SW'(1) << (W - 1)) - SW'(1);
  localparam logic signed [SW-1:0] SatLo  = ~SatHi;
  localparam logic [SqW:0]         Four   = (SqW + 1)'(4) << FracBits;
  localparam logic [PmRawW-1:0]    PmLim  = PmRawW'(1) << (FracBits + 5);

  function automatic logic signed [W-1:0] sat_q(input logic signed [SW-1:0] v);
    if (v > SatHi) begin
      return QMax;
    end else if (v < SatLo) begin
      return QMin;
    end
    return v[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] to_q(input logic [QW-1:0] quo,
                                               input logic big,
                                               input logic neg);
    logic [QW:0]  mag_r;
    logic [W-1:0] mag;
    mag_r = ({1'b0, quo} + (QW + 1)'(1)) >> 1;
    if (big || (mag_r > (QW + 1)'(MagLim))) begin
      mag = MagLim;
    end else begin
      mag = mag_r[W-1:0];
    end
    if (neg) begin
      return $signed(~mag + W'(1));
    end else if (mag == MagLim) begin
      return QMax;
    end
    return $signed(mag);
  endfunction

  // configuration
  logic [GW-1:0]                   grid_q;
  logic [mbet_pkg::MAXIT_W-1:0]    max_iter_q;

  // sequencer and datapath
  mbet_pkg::state_e                state_q, state_d;
  logic                            negx_q, negy_q;
  logic [NW-1:0]                   my_q;
  logic signed [W-1:0]             cx_q, cy_q, x_q, y_q;
  logic [SqW-1:0]                  xx_q, yy_q;
  logic [IW-1:0]                   count_q;
  logic                            esc_q;

  // output word
  logic                            out_valid_q;
  logic [IW-1:0]                   iter_count_q;
  logic                            escaped_q;

  // control
  logic                            div_start, div_done, div_big;
  logic [QW-1:0]                   div_quo;
  logic                            mul_start, mul_done;
  logic [2*W-1:0]                  mul_prod;
  logic                            out_load;

  // combinational datapath
  logic [GW-1:0]                   grid_n;
  logic [RW-1:0]                   half;
  logic [NW-1:0]                   dx, dy, absx, absy, mx, my;
  logic [NW-1:0]                   div_num;
  logic [W-1:0]                    ax, ay, mul_a, mul_b;
  logic [SqW:0]                    sumsq;
  logic                            esc_now, lim_now;
  logic [PmRawW-1:0]               pm_raw;
  logic [PmW-1:0]                  pm;
  logic                            inx;
  logic signed [SW-1:0]            xy;
  logic signed [W-1:0]             x_new, y_new;
  logic signed [W-1:0]             cvt;

  assign grid_n = (grid_q < GW'(2)) ? GW'(2) : ((grid_q > GridCap) ? GridCap : grid_q);
  assign half   = grid_n[GW-1:1];
  assign dx     = {2'b00, row_i} - {2'b00, half};
  assign dy     = {2'b00, col_i} - {2'b00, half};
  assign absx   = dx[NW-1] ? (NW'(0) - dx) : dx;
  assign absy   = dy[NW-1] ? (NW'(0) - dy) : dy;
  assign mx     = {absx[RW-1:0], 2'b00};
  assign my     = {absy[RW-1:0], 2'b00};
  assign div_num = (state_q == mbet_pkg::ST_IDLE) ? mx : my_q;

  assign ax = x_q[W-1] ? (W'(0) - W'(x_q)) : W'(x_q);
  assign ay = y_q[W-1] ? (W'(0) - W'(y_q)) : W'(y_q);

  assign sumsq   = {1'b0, xx_q} + {1'b0, yy_q};
  assign esc_now = sumsq > Four;
  assign lim_now = count_q >= IW'(max_iter_q);

  assign pm_raw = mul_prod[2*W-1:FracBits-1];
  assign inx    = |mul_prod[FracBits-2:0];
  assign pm     = (pm_raw > PmLim) ? PmLim[PmW-1:0] : pm_raw[PmW-1:0];
  assign xy     = (x_q[W-1] != y_q[W-1]) ? (SW'(0) - SW'(pm) - SW'(inx)) : SW'(pm);
  assign y_new  = sat_q(xy + SW'(cy_q));
  assign x_new  = sat_q($signed(SW'(xx_q)) - $signed(SW'(yy_q)) + SW'(cx_q));
  assign cvt    = to_q(div_quo, div_big,
                       (state_q == mbet_pkg::ST_DIV_X) ? negx_q : negy_q);

  always_comb begin
    case (state_q)
      mbet_pkg::ST_MUL_XX: begin
        mul_a = ay;
        mul_b = ay;
      end
      mbet_pkg::ST_CHECK: begin
        mul_a = ax;
        mul_b = ay;
      end
      default: begin
        mul_a = ax;
        mul_b = ax;
      end
    endcase
  end

  mbet_div #(
    .FracBits (FracBits)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (grid_n),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .big_o   (div_big)
  );

  mbet_mul #(
    .Width (W)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mbet_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = mbet_pkg::ST_DIV_X;
      end
      mbet_pkg::ST_DIV_X: begin
        if (div_done) state_d = mbet_pkg::ST_DIV_Y;
      end
      mbet_pkg::ST_DIV_Y: begin
        if (div_done) state_d = mbet_pkg::ST_ITER;
      end
      mbet_pkg::ST_ITER: begin
        state_d = mbet_pkg::ST_MUL_XX;
      end
      mbet_pkg::ST_MUL_XX: begin
        if (mul_done) state_d = mbet_pkg::ST_MUL_YY;
      end
      mbet_pkg::ST_MUL_YY: begin
        if (mul_done) state_d = mbet_pkg::ST_CHECK;
      end
      mbet_pkg::ST_CHECK: begin
        if (esc_now || lim_now) state_d = mbet_pkg::ST_DONE;
        else state_d = mbet_pkg::ST_MUL_XY;
      end
      mbet_pkg::ST_MUL_XY: begin
        if (mul_done) state_d = mbet_pkg::ST_ITER;
      end
      mbet_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) state_d = mbet_pkg::ST_IDLE;
      end
      default: begin
        state_d = mbet_pkg::ST_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o = (state_q != mbet_pkg::ST_IDLE);
    div_start  = 1'b0;
    mul_start  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      mbet_pkg::ST_IDLE:   div_start = in_valid_i;
      mbet_pkg::ST_DIV_X:  div_start = div_done;
      mbet_pkg::ST_ITER:   mul_start = 1'b1;
      mbet_pkg::ST_MUL_XX: mul_start = mul_done;
      mbet_pkg::ST_CHECK:  mul_start = !esc_now && !lim_now;
      mbet_pkg::ST_DONE:   out_load  = !out_valid_q || !out_stall_i;
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mbet_pkg::ST_IDLE;
      grid_q      <= mbet_pkg::GRID_RESET;
      max_iter_q  <= mbet_pkg::MAXIT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mbet_pkg::CFG_GRID_SIZE: grid_q     <= cfg_data_i[GW-1:0];
          mbet_pkg::CFG_MAX_ITER:  max_iter_q <= cfg_data_i;
          default: begin
            grid_q <= grid_q;
          end
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      mbet_pkg::ST_IDLE: begin
        negx_q <= dx[NW-1];
        negy_q <= dy[NW-1];
        my_q   <= my;
      end
      mbet_pkg::ST_DIV_X: begin
        if (div_done) cx_q <= cvt;
      end
      mbet_pkg::ST_DIV_Y: begin
        if (div_done) begin
          cy_q    <= cvt;
          x_q     <= cx_q;
          y_q     <= cvt;
          count_q <= IW'(1);
        end
      end
      mbet_pkg::ST_MUL_XX: begin
        if (mul_done) xx_q <= mul_prod[FracBits +: SqW];
      end
      mbet_pkg::ST_MUL_YY: begin
        if (mul_done) yy_q <= mul_prod[FracBits +: SqW];
      end
      mbet_pkg::ST_CHECK: begin
        esc_q <= esc_now;
        if (!esc_now) count_q <= count_q + IW'(1);
      end
      mbet_pkg::ST_MUL_XY: begin
        if (mul_done) begin
          x_q <= x_new;
          y_q <= y_new;
        end
      end
      default: begin
        esc_q <= esc_q;
      end
    endcase
    if (out_load) begin
      iter_count_q <= count_q;
      escaped_q    <= esc_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign iter_count_o = iter_count_q;
  assign escaped_o    = escaped_q;

  a_mul_done_in_mul_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == mbet_pkg::ST_MUL_XX) || (state_q == mbet_pkg::ST_MUL_YY) ||
                 (state_q == mbet_pkg::ST_MUL_XY))
    else $error("multiplier finished outside a multiply phase");

  a_div_done_in_div_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == mbet_pkg::ST_DIV_X) || (state_q == mbet_pkg::ST_DIV_Y))
    else $error("divider finished outside a conversion phase");

  a_count_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mbet_pkg::ST_CHECK) |->
      (count_q <= IW'(max_iter_q)) || (count_q == IW'(1)))
    else $error("loop count ran past the iteration limit");

  a_limit_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mbet_pkg::ST_DONE) && !esc_q |->
      (count_q == IW'(max_iter_q) + IW'(1)) ||
      ((max_iter_q == '0) && (count_q == IW'(2))))
    else $error("non-escaped word has wrong final count");

  a_word_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == mbet_pkg::ST_DONE)
    else $error("output word raised without a finished pixel");

endmodule

### rtl/core/mbet_div.sv
// ----------------------------------------------------------------------------
// mbet_div
// restoring divider, one quotient bit per cycle, with overflow flag
// ----------------------------------------------------------------------------
module mbet_div #(
  parameter int unsigned FracBits = 28
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [mbet_pkg::NUM_W-1:0]    num_i,
  input  logic [mbet_pkg::GRID_W-1:0]   den_i,
  output logic                          done_o,
  output logic [FracBits+4:0]           quo_o,
  output logic                          big_o
);

  localparam int unsigned QW    = FracBits + 5;
  localparam int unsigned Steps = mbet_pkg::NUM_W + FracBits + 1;
  localparam int unsigned CntW  = $clog2(Steps + 1);
  localparam int unsigned RemW  = mbet_pkg::GRID_W;

  logic                          run_q;
  logic [CntW-1:0]               cnt_q;
  logic [mbet_pkg::NUM_W-1:0]    num_q;
  logic [RemW-1:0]               den_q;
  logic [RemW-1:0]               rem_q;
  logic [QW-1:0]                 quo_q;
  logic                          big_q;

  logic [RemW:0]                 rem2;
  logic [RemW:0]                 rem_sub;
  logic                          ge;
  logic [RemW-1:0]               rem_d;

  assign rem2    = {rem_q, num_q[mbet_pkg::NUM_W-1]};
  assign rem_sub = rem2 - {1'b0, den_q};
  assign ge      = rem2 >= {1'b0, den_q};
  assign rem_d   = ge ? rem_sub[RemW-1:0] : rem2[RemW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= CntW'(Steps);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CntW'(1);
    end else begin
      run_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
      big_q <= 1'b0;
    end else if (cnt_q != '0) begin
      num_q <= num_q << 1;
      rem_q <= rem_d;
      quo_q <= {quo_q[QW-2:0], ge};
      big_q <= big_q | quo_q[QW-1];
    end
  end

  assign done_o = run_q && (cnt_q == '0);
  assign quo_o  = quo_q;
  assign big_o  = big_q;

endmodule

### rtl/core/mbet_mul.sv
// ----------------------------------------------------------------------------
// mbet_mul
// shared unsigned multiplier, one digit of b per cycle, msb digit first
// ----------------------------------------------------------------------------
module mbet_mul #(
  parameter int unsigned Width = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [Width-1:0]     a_i,
  input  logic [Width-1:0]     b_i,
  output logic                 done_o,
  output logic [2*Width-1:0]   prod_o
);

  localparam int unsigned DigW   = mbet_pkg::DIG_W;
  localparam int unsigned NumDig = (Width + DigW - 1) / DigW;
  localparam int unsigned PadW   = NumDig * DigW;
  localparam int unsigned PpW    = Width + DigW;
  localparam int unsigned AccW   = Width + PadW;
  localparam int unsigned CntW   = (NumDig > 1) ? $clog2(NumDig) : 1;

  logic                pp_v_q;
  logic [CntW-1:0]     cnt_q;
  logic [Width-1:0]    a_q;
  logic [PadW-1:0]     b_q;
  logic [PpW-1:0]      pp_q;
  logic [AccW-1:0]     acc_q;

  logic [PadW-1:0]     b_pad;
  logic [AccW-1:0]     acc_sum;

  assign b_pad   = PadW'(b_i);
  assign acc_sum = (acc_q << DigW) + AccW'(pp_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pp_v_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      pp_v_q <= 1'b1;
      cnt_q  <= CntW'(NumDig - 1);
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - CntW'(1);
    end else begin
      pp_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_pad << DigW;
      pp_q  <= PpW'(a_i) * PpW'(b_pad[PadW-1 -: DigW]);
      acc_q <= '0;
    end else if (cnt_q != '0) begin
      b_q   <= b_q << DigW;
      pp_q  <= PpW'(a_q) * PpW'(b_q[PadW-1 -: DigW]);
      acc_q <= acc_sum;
    end
  end

  assign done_o = pp_v_q && (cnt_q == '0);
  assign prod_o = acc_sum[2*Width-1:0];

endmodule

### sim/mandelbrot_escape_time_core_tb.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_core_tb
// self-checking testbench of the escape-time core
// ----------------------------------------------------------------------------
// Every pixel accepted on the input channel is run through a fixed-point
// escape-time predictor in the testbench and its count and escaped flag are
// queued. Each word taken from the output channel is compared against the
// oldest queued one. Directed pixels cover the register reset values, the
// iteration limit extremes, grid sizes below and above the legal range and
// pixels outside the grid. Random traffic then runs under several
// sender/receiver idle mixes, with a long receiver hold-off that fills the
// core and pushes back on the sender.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_GRID    = 4096;
  localparam int unsigned FRAC_BITS   = 28;
  localparam int unsigned CYCLE_LIMIT = 6_000_000;

  localparam longint Q_SPAN       = 64'sd1 << (FRAC_BITS + 3);
  localparam longint Q_HI         = Q_SPAN - 1;
  localparam longint Q_LO         = -Q_SPAN;
  localparam longint ESCAPE_BOUND = 64'sd4 << FRAC_BITS;
  localparam longint CROSS_CAP    = 64'sd1 << (FRAC_BITS + 5);
  localparam longint CROSS_MASK   = (64'sd1 << (FRAC_BITS - 1)) - 1;

  typedef struct {
    logic [mbet_pkg::ROW_W-1:0]  row;
    logic [mbet_pkg::ROW_W-1:0]  col;
    logic [mbet_pkg::ITER_W-1:0] iter_count;
    logic                        escaped;
  } escape_result_t;

  logic                            clk_i;
  logic                            rst_ni       = 1'b0;
  logic                            cfg_we_i     = 1'b0;
  logic [mbet_pkg::CFG_IDX_W-1:0]  cfg_idx_i    = mbet_pkg::CFG_GRID_SIZE;
  logic [mbet_pkg::CFG_DATA_W-1:0] cfg_data_i   = '0;
  logic                            in_valid_i   = 1'b0;
  logic                            in_stall_o;
  logic [mbet_pkg::ROW_W-1:0]      row_i        = '0;
  logic [mbet_pkg::ROW_W-1:0]      col_i        = '0;
  logic                            out_valid_o;
  logic                            out_stall_i  = 1'b0;
  logic [mbet_pkg::ITER_W-1:0]     iter_count_o;
  logic                            escaped_o;

  logic [mbet_pkg::GRID_W-1:0]  grid_size_cfg = mbet_pkg::GRID_RESET;
  logic [mbet_pkg::MAXIT_W-1:0] max_iter_cfg  = mbet_pkg::MAXIT_RESET;

  escape_result_t expected_escapes[$];
  int unsigned    mismatches    = 0;
  int unsigned    cycle_count   = 0;
  int unsigned    hold_left     = 0;
  int unsigned    send_idle_pct = 0;
  int unsigned    stall_pct     = 0;

  mandelbrot_escape_time_core #(
    .MaxGrid  (MAX_GRID),
    .FracBits (FRAC_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .row_i        (row_i),
    .col_i        (col_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .iter_count_o (iter_count_o),
    .escaped_o    (escaped_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d words outstanding", $time, expected_escapes.size());
      $display("mandelbrot_escape_time_core verification failed");
      $finish;
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------
  function automatic longint grid_span();
    longint n;
    n = grid_size_cfg;
    if (n < 2) n = 2;
    if (n > MAX_GRID) n = MAX_GRID;
    return n;
  endfunction

  function automatic longint clamp_q(longint v);
    if (v > Q_HI) return Q_HI;
    if (v < Q_LO) return Q_LO;
    return v;
  endfunction

  // 4*d/n rounded to nearest, ties away from zero
  function automatic longint coord_to_q(longint d, longint n);
    longint m, q, r, frac, mag;
    m = ((d < 0) ? -d : d) * 4;
    q = m / n;
    r = m % n;
    if (q >= 8) begin
      mag = Q_SPAN;
    end else begin
      frac = (r << (FRAC_BITS + 1)) / n;
      mag = (q << FRAC_BITS) + ((frac + 1) >> 1);
      if (mag > Q_SPAN) mag = Q_SPAN;
    end
    if (d < 0) return clamp_q(-mag);
    if (mag > Q_HI) return Q_HI;
    return mag;
  endfunction

  function automatic escape_result_t escape_time(logic [mbet_pkg::ROW_W-1:0] row,
                                                 logic [mbet_pkg::ROW_W-1:0] col);
    escape_result_t res;
    longint n, half, rv, cv, cx, cy, x, y, ax, ay, xx, yy, prod, pm, xy;
    int unsigned count;
    logic esc;
    n = grid_span();
    half = n / 2;
    rv = row;
    cv = col;
    cx = coord_to_q(rv - half, n);
    cy = coord_to_q(cv - half, n);
    x = cx;
    y = cy;
    count = 1;
    esc = 1'b0;
    forever begin
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      xx = (ax * ax) >> FRAC_BITS;
      yy = (ay * ay) >> FRAC_BITS;
      if (xx + yy > ESCAPE_BOUND) begin
        esc = 1'b1;
        break;
      end
      if (count >= max_iter_cfg) begin
        count++;
        break;
      end
      count++;
      prod = ax * ay;
      pm = prod >> (FRAC_BITS - 1);
      if (pm > CROSS_CAP) pm = CROSS_CAP;
      // floor of a negative product drops one more lsb when bits are lost
      if ((x < 0) != (y < 0)) xy = -pm - (((prod & CROSS_MASK) != 0) ? 1 : 0);
      else xy = pm;
      x = clamp_q(xx - yy + cx);
      y = clamp_q(xy + cy);
    end
    res.row = row;
    res.col = col;
    res.iter_count = count[mbet_pkg::ITER_W-1:0];
    res.escaped = esc;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // output side: random stall and compare
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    escape_result_t exp_word;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_escapes.size() == 0) begin
        $display("%0t: unexpected word, iter_count %0d escaped %0d",
                 $time, iter_count_o, escaped_o);
        mismatches++;
      end else begin
        exp_word = expected_escapes.pop_front();
        if (iter_count_o !== exp_word.iter_count) begin
          $display("%0t: pixel (%0d,%0d) iter_count expected %0d actual %0d", $time,
                   exp_word.row, exp_word.col, exp_word.iter_count, iter_count_o);
          mismatches++;
        end
        if (escaped_o !== exp_word.escaped) begin
          $display("%0t: pixel (%0d,%0d) escaped expected %0d actual %0d", $time,
                   exp_word.row, exp_word.col, exp_word.escaped, escaped_o);
          mismatches++;
        end
      end
    end
    out_stall_i <= (hold_left > 0) || ($urandom_range(99) < stall_pct);
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [mbet_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mbet_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      mbet_pkg::CFG_GRID_SIZE: grid_size_cfg = data[mbet_pkg::GRID_W-1:0];
      mbet_pkg::CFG_MAX_ITER:  max_iter_cfg  = data[mbet_pkg::MAXIT_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_pixel(input logic [mbet_pkg::ROW_W-1:0] row,
                            input logic [mbet_pkg::ROW_W-1:0] col);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    row_i      <= row;
    col_i      <= col;
    do @(posedge clk_i); while (in_stall_o);
    expected_escapes.push_back(escape_time(row, col));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_escapes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic [mbet_pkg::ROW_W-1:0] pick_coord();
    longint      span;
    int unsigned n;
    int unsigned v;
    span = grid_span();
    n = span[31:0];
    if ($urandom_range(99) < 80) v = $urandom_range(0, n - 1);
    else v = $urandom_range(0, (1 << mbet_pkg::ROW_W) - 1);
    return v[mbet_pkg::ROW_W-1:0];
  endfunction

  task automatic randomize_setting();
    logic [mbet_pkg::CFG_DATA_W-1:0] grid, limit;
    int unsigned pick;
    int unsigned v;
    pick = $urandom_range(99);
    if (pick < 10) v = $urandom_range(2, 16);
    else if (pick < 15) v = $urandom_range(0, 16'hFFFF);
    else v = $urandom_range(2, MAX_GRID);
    grid = v[mbet_pkg::CFG_DATA_W-1:0];
    pick = $urandom_range(99);
    if (pick < 5) v = 0;
    else if (pick < 15) v = $urandom_range(41, 255);
    else v = $urandom_range(1, 40);
    limit = v[mbet_pkg::CFG_DATA_W-1:0];
    write_reg(mbet_pkg::CFG_GRID_SIZE, grid);
    write_reg(mbet_pkg::CFG_MAX_ITER, limit);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_values();
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1024, 12'd1024);
    send_pixel(12'd1536, 12'd1024);
    drain();
  endtask

  task automatic test_iteration_limits();
    write_reg(mbet_pkg::CFG_GRID_SIZE, 16'd64);
    write_reg(mbet_pkg::CFG_MAX_ITER, 16'd0);
    send_pixel(12'd32, 12'd32);
    send_pixel(12'd0, 12'd0);
    drain();
    write_reg(mbet_pkg::CFG_MAX_ITER, 16'd1);
    send_pixel(12'd32, 12'd32);
    send_pixel(12'd40, 12'd20);
    drain();
    write_reg(mbet_pkg::CFG_MAX_ITER, 16'hFFFF);
    send_pixel(12'd32, 12'd32);
    send_pixel(12'd40, 12'd33);
    drain();
  endtask

  task automatic test_grid_extremes();
    write_reg(mbet_pkg::CFG_MAX_ITER, 16'd20);
    write_reg(mbet_pkg::CFG_GRID_SIZE, 16'd0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd1);
    send_pixel(12'd4095, 12'd4095);
    drain();
    write_reg(mbet_pkg::CFG_GRID_SIZE, 16'd1);
    send_pixel(12'd1, 12'd0);
    drain();
    write_reg(mbet_pkg::CFG_GRID_SIZE, 16'd3);
    send_pixel(12'd2, 12'd1);
    send_pixel(12'd4095, 12'd0);
    drain();
    // all data bits set, beyond the widest legal grid
    write_reg(mbet_pkg::CFG_GRID_SIZE, 16'hFFFF);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd2048, 12'd2048);
    send_pixel(12'd0, 12'd4095);
    drain();
    write_reg(mbet_pkg::CFG_GRID_SIZE, 16'd4095);
    send_pixel(12'd2047, 12'd2047);
    send_pixel(12'd1500, 12'd2900);
    drain();
  endtask

  task automatic test_random_traffic(input int unsigned items, input int unsigned idle_p,
                                     input int unsigned stall_p);
    send_idle_pct = idle_p;
    stall_pct     = stall_p;
    for (int half_idx = 0; half_idx < 2; half_idx++) begin
      randomize_setting();
      for (int unsigned k = 0; k < items / 2; k++) begin
        send_pixel(pick_coord(), pick_coord());
      end
      drain();
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    write_reg(mbet_pkg::CFG_GRID_SIZE, 16'd64);
    write_reg(mbet_pkg::CFG_MAX_ITER, 16'd4);
    hold_left <= 1500;
    for (int k = 0; k < 12; k++) begin
      send_pixel(pick_coord(), pick_coord());
    end
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_iteration_limits();
    test_grid_extremes();
    test_random_traffic(150, 0, 0);
    test_random_traffic(150, 86, 0);
    test_random_traffic(150, 0, 86);
    test_random_traffic(150, 27, 27);
    test_backpressure();

    drain();
    repeat (100) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("mandelbrot_escape_time_core verification clean");
    end else begin
      $display("mandelbrot_escape_time_core verification failed");
    end
    $finish;
  end

endmodule
